[rtl/lfr_pkg.sv]
// Shared types and constants of the link frame receiver.
// No dependencies; every module of the block imports this package.
package lfr_pkg;

  // Line codes
  localparam logic [7:0] FLAG_BYTE    = 8'h7E;
  localparam logic [7:0] ESC_BYTE     = 8'h7D;
  localparam logic [7:0] ESC_FLAG     = 8'h5E;
  localparam logic [7:0] ESC_ESC      = 8'h5D;
  localparam logic [7:0] ESC_NUL      = 8'h20;
  localparam logic [7:0] NUL_BYTE     = 8'h00;
  localparam logic [7:0] CTL_SEQ1     = 8'h40;
  localparam logic [7:0] CTL_SEQ0     = 8'h00;

  // Supervisory reply bytes
  localparam logic [7:0] RR_SEQ0      = 8'h85;
  localparam logic [7:0] RR_SEQ1      = 8'h05;
  localparam logic [7:0] REJ_SEQ0     = 8'h81;
  localparam logic [7:0] REJ_SEQ1     = 8'h01;

  // Frame status codes
  localparam logic [2:0] STAT_OK      = 3'd0;
  localparam logic [2:0] STAT_DUP     = 3'd1;
  localparam logic [2:0] STAT_DISC    = 3'd2;
  localparam logic [2:0] STAT_BAD     = 3'd3;
  localparam logic [2:0] STAT_HCS     = 3'd4;
  localparam logic [2:0] STAT_DCS     = 3'd5;

  // Result kinds
  localparam logic       KIND_PAYLOAD = 1'b0;
  localparam logic       KIND_REPORT  = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_EXP_SEQ  = 2'd0;
  localparam logic [1:0] REG_DISC     = 2'd1;
  localparam logic [1:0] REG_MAX      = 2'd2;

  // Result queue depth (power of two) and pointer width
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  typedef struct packed {
    logic        exp_seq;
    logic [7:0]  disc_code;
    logic [15:0] max_bytes;
  } lfr_cfg_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [2:0]  frame_status;
    logic [15:0] payload_length;
    logic        reply_valid;
    logic [7:0]  reply_control;
    logic        last;
  } lfr_result_t;

  // Up to two results written into the queue per accepted byte
  typedef struct packed {
    logic [1:0]  count;
    lfr_result_t res0;
    lfr_result_t res1;
  } lfr_qwrite_t;

endpackage

[rtl/lfr_front.sv]
// Front end: takes line bytes, tracks framing and destuffing, builds results.
// Depends on lfr_pkg; feeds lfr_queue.
module lfr_front import lfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  lfr_cfg_t    cfg,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        q_ready,
  output lfr_qwrite_t q_wr
);

  typedef struct packed {
    logic        in_frame;
    logic        escape_pending;
    logic [15:0] byte_index;
    logic [7:0]  address_seen;
    logic [7:0]  control_seen;
    logic [7:0]  header_check_seen;
    logic [7:0]  held_byte;
    logic        held_valid;
    logic [7:0]  data_xor;
    logic        overflowed;
    logic [16:0] line_count;
  } lfr_fstate_t;

  typedef struct packed {
    lfr_fstate_t st;
    logic        emit;
    logic [7:0]  data;
  } lfr_push_t;

  // Fresh frame after an opening flag
  function automatic lfr_fstate_t open_frame();
    lfr_fstate_t s;
    s = '0;
    s.in_frame   = 1'b1;
    s.line_count = 17'd1;
    return s;
  endfunction

  // One destuffed byte: header capture or payload with one-byte hold
  function automatic lfr_push_t push_byte(lfr_fstate_t s, logic [7:0] b);
    lfr_push_t p;
    p.st   = s;
    p.emit = 1'b0;
    p.data = s.held_byte;
    if (s.byte_index == 16'd0) begin
      p.st.address_seen = b;
    end else if (s.byte_index == 16'd1) begin
      p.st.control_seen = b;
    end else if (s.byte_index == 16'd2) begin
      p.st.header_check_seen = b;
    end else begin
      if (s.held_valid) begin
        p.emit = 1'b1;
        p.st.data_xor = s.data_xor ^ s.held_byte;
      end
      p.st.held_byte  = b;
      p.st.held_valid = 1'b1;
    end
    if (s.byte_index != 16'hFFFF) begin
      p.st.byte_index = s.byte_index + 16'd1;
    end
    return p;
  endfunction

  function automatic lfr_result_t payload_res(logic [7:0] b);
    lfr_result_t r;
    r = '0;
    r.kind         = KIND_PAYLOAD;
    r.payload_byte = b;
    return r;
  endfunction

  // End of frame report with status priority and reply selection
  function automatic lfr_result_t report_res(lfr_fstate_t s, lfr_cfg_t c);
    lfr_result_t r;
    logic        hcs_ok;
    logic [7:0]  exp_ctl;
    logic [7:0]  other_ctl;
    r         = '0;
    r.kind    = KIND_REPORT;
    hcs_ok    = (s.header_check_seen == (s.address_seen ^ s.control_seen));
    exp_ctl   = c.exp_seq ? CTL_SEQ1 : CTL_SEQ0;
    other_ctl = c.exp_seq ? CTL_SEQ0 : CTL_SEQ1;
    if (s.overflowed || (s.byte_index < 16'd4)) begin
      r.frame_status = STAT_BAD;
    end else if ((s.control_seen == c.disc_code) && hcs_ok) begin
      r.frame_status = STAT_DISC;
    end else if ((s.control_seen != exp_ctl) && (s.control_seen == other_ctl)) begin
      r.frame_status = STAT_DUP;
    end else if (!hcs_ok) begin
      r.frame_status = STAT_HCS;
    end else if (s.held_byte != s.data_xor) begin
      r.frame_status = STAT_DCS;
    end else begin
      r.frame_status = STAT_OK;
    end
    r.reply_valid = 1'b1;
    unique case (r.frame_status)
      STAT_OK: begin
        r.payload_length = s.byte_index - 16'd4;
        r.reply_control  = c.exp_seq ? RR_SEQ1 : RR_SEQ0;
      end
      STAT_DUP: begin
        r.reply_control  = c.exp_seq ? RR_SEQ0 : RR_SEQ1;
      end
      STAT_DISC: begin
        r.reply_valid    = 1'b0;
        r.reply_control  = 8'h00;
      end
      default: begin
        r.reply_control  = c.exp_seq ? REJ_SEQ1 : REJ_SEQ0;
      end
    endcase
    return r;
  endfunction

  lfr_fstate_t state_r, state_nxt;
  lfr_result_t res_a [2];
  logic [1:0]  n_res;
  lfr_push_t   p;
  logic        accept;

  assign in_tready = q_ready;
  assign accept    = in_tvalid && in_tready;

  // Per-byte step: state update and up to two results in order
  always_comb begin
    state_nxt = state_r;
    res_a[0]  = '0;
    res_a[1]  = '0;
    n_res     = 2'd0;
    p         = '0;
    if (!state_r.in_frame) begin
      if (in_tdata == FLAG_BYTE) begin
        state_nxt = open_frame();
      end
    end else begin
      // line byte count and overflow
      if (state_nxt.line_count != 17'h1FFFF) begin
        state_nxt.line_count = state_nxt.line_count + 17'd1;
      end
      if (state_nxt.line_count > {1'b0, cfg.max_bytes}) begin
        state_nxt.overflowed = 1'b1;
      end

      if (in_tdata == FLAG_BYTE) begin
        // dangling escape before the flag counts as a literal escape byte
        if (!state_nxt.overflowed && state_nxt.escape_pending) begin
          p = push_byte(state_nxt, ESC_BYTE);
          state_nxt = p.st;
          if (p.emit) begin
            res_a[n_res[0]] = payload_res(p.data);
            n_res = n_res + 2'd1;
          end
        end
        state_nxt.escape_pending = 1'b0;
        if ((state_nxt.byte_index == 16'd0) && !state_nxt.overflowed) begin
          // idle flag
          state_nxt.line_count = 17'd1;
        end else begin
          res_a[n_res[0]] = report_res(state_nxt, cfg);
          n_res = n_res + 2'd1;
          state_nxt = open_frame();
        end
      end else if (!state_nxt.overflowed) begin
        if (state_nxt.escape_pending) begin
          state_nxt.escape_pending = 1'b0;
          case (in_tdata)
            ESC_FLAG: p = push_byte(state_nxt, FLAG_BYTE);
            ESC_ESC:  p = push_byte(state_nxt, ESC_BYTE);
            ESC_NUL:  p = push_byte(state_nxt, NUL_BYTE);
            default:  p = push_byte(state_nxt, ESC_BYTE);
          endcase
          state_nxt = p.st;
          if (p.emit) begin
            res_a[n_res[0]] = payload_res(p.data);
            n_res = n_res + 2'd1;
          end
          // unknown escape: the following byte is handled normally
          if ((in_tdata != ESC_FLAG) && (in_tdata != ESC_ESC) && (in_tdata != ESC_NUL)) begin
            if (in_tdata == ESC_BYTE) begin
              state_nxt.escape_pending = 1'b1;
            end else begin
              p = push_byte(state_nxt, in_tdata);
              state_nxt = p.st;
              if (p.emit) begin
                res_a[n_res[0]] = payload_res(p.data);
                n_res = n_res + 2'd1;
              end
            end
          end
        end else if (in_tdata == ESC_BYTE) begin
          state_nxt.escape_pending = 1'b1;
        end else begin
          p = push_byte(state_nxt, in_tdata);
          state_nxt = p.st;
          if (p.emit) begin
            res_a[n_res[0]] = payload_res(p.data);
            n_res = n_res + 2'd1;
          end
        end
      end
    end

    // mark the last result of this byte
    if (n_res == 2'd2) begin
      res_a[1].last = 1'b1;
    end else if (n_res == 2'd1) begin
      res_a[0].last = 1'b1;
    end
  end

  // Queue write request
  always_comb begin
    q_wr.count = accept ? n_res : 2'd0;
    q_wr.res0  = res_a[0];
    q_wr.res1  = res_a[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (accept) begin
      state_r <= state_nxt;
    end
  end

endmodule

[rtl/lfr_queue.sv]
// Result queue between front and back: up to two writes, one read per cycle.
// Depends on lfr_pkg; written by lfr_front, drained by lfr_back.
module lfr_queue import lfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  lfr_qwrite_t q_wr,
  output logic        q_ready,
  output logic        q_valid,
  output lfr_result_t q_data,
  input  logic        q_pop
);

  lfr_result_t       mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              rd;

  // Room for the worst case of two results per byte
  assign q_ready = (count_r <= QCNT_W'(QDEPTH - 2));
  assign q_valid = (count_r != '0);
  assign q_data  = mem_r[rd_ptr_r];
  assign rd      = q_valid && q_pop;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QPTR_W'(q_wr.count);
    rd_ptr_nxt = rd_ptr_r + QPTR_W'(rd);
    count_nxt  = count_r + QCNT_W'(q_wr.count) - QCNT_W'(rd);
  end

  // Storage
  always_ff @(posedge clk) begin
    if (q_wr.count != 2'd0) begin
      mem_r[wr_ptr_r] <= q_wr.res0;
    end
    if (q_wr.count == 2'd2) begin
      mem_r[wr_ptr_r + QPTR_W'(1)] <= q_wr.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.count != 2'd0 |-> count_r <= QCNT_W'(QDEPTH - 2))
    else $error("queue written without room");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (q_wr.count == 2'd0 && !rd) |=> $stable(count_r))
    else $error("queue count moved without traffic");
  a_wr_count: assert property (@(posedge clk) disable iff (!rst_n)
    q_wr.count != 2'd3)
    else $error("more than two results from one byte");
`endif

endmodule

[rtl/lfr_back.sv]
// Back end: output register stage that drains the queue onto the result stream.
// Depends on lfr_pkg; reads lfr_queue.
module lfr_back import lfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  lfr_result_t q_data,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  output logic        out_tuser,
  output logic        out_tlast
);

  logic        out_valid_r, out_valid_nxt;
  lfr_result_t out_data_r;

  // Load whenever the register is empty or being taken
  assign q_pop         = q_valid && (!out_valid_r || out_tready);
  assign out_valid_nxt = q_pop || (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= q_data;
    end
  end

  // Pack fields, highest first
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_data_r.reply_control, out_data_r.reply_valid,
                       out_data_r.payload_length, out_data_r.frame_status,
                       out_data_r.payload_byte};
  assign out_tuser  = out_data_r.kind;
  assign out_tlast  = out_data_r.last;

endmodule

[rtl/link_frame_receiver_top.sv]
// Link frame receiver, top level: configuration registers and the three stages.
// Depends on lfr_pkg, lfr_front, lfr_queue and lfr_back.
//
// Usage:
//   in_*  : raw line bytes, one per request (in_tdata[7:0]).
//   out_* : results. out_tuser is the kind (0 payload byte, 1 end of frame
//           report); out_tlast marks the last result caused by one line byte.
//   cfg_* : register writes, always ready; index 0 expected sequence bit,
//           1 disconnect control code, 2 largest frame length in line bytes.
//           Write only while no results are outstanding.
// Timing:
//   An accepted byte's results go into the result queue, then through the
//   output register onto out_*. One byte per cycle is sustained while each
//   byte makes at most one result and out_tready is high; a byte may make
//   two, which the output drains at one per cycle. in_tready follows the
//   four-entry result queue: it drops when fewer than two entries are free.
// Reset: synchronous, active low rst_n. The receiver waits for a flag, the
//   queue empties and registers take their reset values (sequence 0,
//   disconnect code 11, frame limit 1024).
// Stall: when out_tready is low the output holds, the queue fills and
//   in_tready drops; no result is lost.
module link_frame_receiver_top import lfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // line_byte[7:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // payload_byte[7:0], frame_status[10:8],
                                   // payload_length[26:11], reply_valid[27],
                                   // reply_control[35:28], zero fill[39:36]
  output logic        out_tuser,   // kind[0]
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  lfr_cfg_t    cfg_r;
  lfr_qwrite_t q_wr;
  logic        q_ready;
  logic        q_valid;
  lfr_result_t q_data;
  logic        q_pop;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.exp_seq   <= 1'b0;
      cfg_r.disc_code <= 8'd11;
      cfg_r.max_bytes <= 16'd1024;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_EXP_SEQ: cfg_r.exp_seq   <= cfg_data[0];
        REG_DISC:    cfg_r.disc_code <= cfg_data[7:0];
        REG_MAX:     cfg_r.max_bytes <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  lfr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_ready   (q_ready),
    .q_wr      (q_wr)
  );

  lfr_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr    (q_wr),
    .q_ready (q_ready),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  lfr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
